// ----- src/ssam_pkg.sv -----
`default_nettype none
package ssam_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 32;
	localparam int MEAN_BITS   = 32;
	localparam int M2_BITS     = 63;
	localparam int CFG_BITS    = 16;
	localparam int HYST_BITS   = 15;
	localparam int DIV_BITS    = 33;
	localparam int DIV_CNT_BITS = 6;
	localparam int FLAG_BITS   = 8;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 176;

	localparam logic [1:0] FUNC_COLLECT = 2'd0;
	localparam logic [1:0] FUNC_FAULT   = 2'd1;
	localparam logic [1:0] FUNC_RESET   = 2'd2;
	localparam logic [1:0] FUNC_TICK    = 2'd3;

	localparam logic [2:0] REG_HI_ERR   = 3'd0;
	localparam logic [2:0] REG_HI_WARN  = 3'd1;
	localparam logic [2:0] REG_LO_WARN  = 3'd2;
	localparam logic [2:0] REG_LO_ERR   = 3'd3;
	localparam logic [2:0] REG_HYST     = 3'd4;
	localparam logic [2:0] REG_LOCKOUT  = 3'd5;

	typedef struct packed {
		logic capture;
		logic simple_op;
		logic div_init;
		logic div_step;
		logic mean_upd;
		logic mul;
		logic acc;
		logic load_out;
	} ssam_cmd_t;

	typedef struct packed {
		logic       collect_go;
		logic       out_free;
	} ssam_status_t;

endpackage
`default_nettype wire

// ----- src/ssam_ctrl.sv -----
`default_nettype none
module ssam_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_fire,
	input  wire ssam_pkg::ssam_status_t status,
	output logic                        idle,
	output ssam_pkg::ssam_cmd_t         cmd
);
	import ssam_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_DIV      = 7'b0000100,
		S_MEAN     = 7'b0001000,
		S_MUL      = 7'b0010000,
		S_ACC      = 7'b0100000,
		S_OUT      = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.capture = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (status.collect_go) begin
					cmd.div_init = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.simple_op = 1'b1;
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) state_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.mean_upd = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

endmodule
`default_nettype wire

// ----- src/ssam_dp.sv -----
`default_nettype none
module ssam_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ssam_pkg::ssam_cmd_t           cmd,
	output ssam_pkg::ssam_status_t             status,
	input  wire logic [1:0]                    in_func,
	input  wire logic [ssam_pkg::IN_DATA_BITS-1:0] in_data,
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [ssam_pkg::CFG_BITS-1:0] cfg_data,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [ssam_pkg::OUT_DATA_BITS-1:0] out_data
);
	import ssam_pkg::*;

	logic signed [CFG_BITS-1:0] hi_err_q, hi_warn_q, lo_warn_q, lo_err_q;
	logic [HYST_BITS-1:0] hyst_q;
	logic [CFG_BITS-1:0] lock_dur_q;

	logic signed [SAMPLE_BITS-1:0] min_q, max_q, sample_q;
	logic signed [MEAN_BITS-1:0] mean_q;
	logic [M2_BITS-1:0] m2_q;
	logic [COUNT_BITS-1:0] count_q;
	logic enabled_q, enable_in_q;
	logic [CFG_BITS-1:0] lock_q;
	logic [FLAG_BITS-1:0] raised_q, changed_q;
	logic [1:0] func_q;

	logic delta_neg_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] a_q;
	logic [31:0] b_q;
	logic skip_q, sat_q;
	logic [63:0] prod_q;

	// Collect setup: delta = sample*2^16 - mean, exact in 34 bits.
	logic signed [DIV_BITS:0] smp_fix, delta, mean_ext;
	logic [DIV_BITS:0] delta_mag;
	logic [COUNT_BITS-1:0] count_inc;
	assign smp_fix  = {{(DIV_BITS+1-SAMPLE_BITS-16){sample_q[SAMPLE_BITS-1]}}, sample_q, 16'd0};
	assign mean_ext = {{(DIV_BITS+1-MEAN_BITS){mean_q[MEAN_BITS-1]}}, mean_q};
	assign delta    = smp_fix - mean_ext;
	assign delta_mag = delta[DIV_BITS] ? (~delta + 1'b1) : delta;
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;

	// Restoring division step.
	logic [COUNT_BITS:0] rem_sh;
	logic rem_ge;
	assign rem_sh = {rem_q, quo_q[DIV_BITS-1]};
	assign rem_ge = rem_sh >= {1'b0, count_q};

	// Mean update and second delta.
	logic signed [DIV_BITS+1:0] q_s, mean_sum;
	logic signed [MEAN_BITS-1:0] mean_new;
	logic signed [DIV_BITS:0] delta2;
	logic [DIV_BITS:0] d2_mag;
	assign q_s = delta_neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign mean_sum = {mean_ext[DIV_BITS], mean_ext} + q_s;
	always_comb begin
		if (mean_sum > $signed({{(DIV_BITS+2-MEAN_BITS){1'b0}}, 1'b0, {(MEAN_BITS-1){1'b1}}}))
			mean_new = {1'b0, {(MEAN_BITS-1){1'b1}}};
		else if (mean_sum < $signed({{(DIV_BITS+2-MEAN_BITS){1'b1}}, 1'b1, {(MEAN_BITS-1){1'b0}}}))
			mean_new = {1'b1, {(MEAN_BITS-1){1'b0}}};
		else
			mean_new = mean_sum[MEAN_BITS-1:0];
	end
	assign delta2 = smp_fix - {{(DIV_BITS+1-MEAN_BITS){mean_new[MEAN_BITS-1]}}, mean_new};
	assign d2_mag = delta2[DIV_BITS] ? (~delta2 + 1'b1) : delta2;

	// M2 accumulate with saturation.
	logic [M2_BITS:0] m2_sum;
	assign m2_sum = {1'b0, m2_q} + {16'd0, prod_q[63:16]};

	// Fault check with hysteresis, computed two bits wider than the thresholds.
	logic signed [CFG_BITS+1:0] v_w, h_w;
	logic [3:0] set_b, clr_b;
	logic [FLAG_BITS-1:0] set_m, clr_m, raised_new;
	function automatic logic signed [CFG_BITS+1:0] wide(input logic signed [CFG_BITS-1:0] x);
		wide = {{2{x[CFG_BITS-1]}}, x};
	endfunction
	always_comb begin
		v_w = {{(CFG_BITS+2-SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};
		h_w = {3'd0, hyst_q};
		set_b = '0;
		clr_b = '0;
		if (v_w > wide(hi_err_q) + h_w) set_b[0] = 1'b1;
		else if (v_w < wide(hi_err_q) - h_w) clr_b[0] = 1'b1;
		if (v_w > wide(hi_warn_q) + h_w) set_b[1] = 1'b1;
		else if (v_w < wide(hi_warn_q) - h_w) clr_b[1] = 1'b1;
		if (v_w < wide(lo_warn_q) - h_w) set_b[2] = 1'b1;
		else if (v_w > wide(lo_warn_q) + h_w) clr_b[2] = 1'b1;
		if (v_w < wide(lo_err_q) - h_w) set_b[3] = 1'b1;
		else if (v_w > wide(lo_err_q) + h_w) clr_b[3] = 1'b1;
		if (enabled_q && lock_q == '0) begin
			set_m = {set_b, set_b};
			clr_m = {clr_b, clr_b};
		end else begin
			set_m = {4'd0, set_b};
			clr_m = {4'd0, clr_b};
		end
		raised_new = (raised_q | set_m) & ~clr_m;
	end

	assign status.collect_go = (func_q == FUNC_COLLECT) && enabled_q;
	assign status.out_free   = !out_valid || out_ready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_err_q <= 16'sh7FFF;
			hi_warn_q <= 16'sh7FFF;
			lo_warn_q <= 16'sh8000;
			lo_err_q <= 16'sh8000;
			hyst_q <= '0;
			lock_dur_q <= '0;
			min_q <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			mean_q <= '0;
			m2_q <= '0;
			count_q <= '0;
			enabled_q <= 1'b0;
			lock_q <= '0;
			raised_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HI_ERR:  hi_err_q <= cfg_data;
					REG_HI_WARN: hi_warn_q <= cfg_data;
					REG_LO_WARN: lo_warn_q <= cfg_data;
					REG_LO_ERR:  lo_err_q <= cfg_data;
					REG_HYST:    hyst_q <= cfg_data[HYST_BITS-1:0];
					REG_LOCKOUT: lock_dur_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.div_init) begin
				if (sample_q < min_q) min_q <= sample_q;
				if (sample_q > max_q) max_q <= sample_q;
				count_q <= count_inc;
			end
			if (cmd.simple_op) begin
				case (func_q)
					FUNC_FAULT: raised_q <= raised_new;
					FUNC_RESET: begin
						mean_q <= '0;
						m2_q <= '0;
						count_q <= '0;
						enabled_q <= enable_in_q;
						lock_q <= lock_dur_q;
					end
					FUNC_TICK: if (lock_q != '0) lock_q <= lock_q - 1'b1;
					default: ;
				endcase
			end
			if (cmd.mean_upd) mean_q <= mean_new;
			if (cmd.acc && !skip_q) begin
				if (sat_q || m2_sum[M2_BITS]) m2_q <= '1;
				else m2_q <= m2_sum[M2_BITS-1:0];
			end
			if (cmd.load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			sample_q <= in_data[SAMPLE_BITS-1:0];
			enable_in_q <= in_data[SAMPLE_BITS];
		end
		if (cmd.simple_op)
			changed_q <= (func_q == FUNC_FAULT) ? (raised_new ^ raised_q) : '0;
		else if (cmd.div_init)
			changed_q <= '0;
		if (cmd.div_init) begin
			delta_neg_q <= delta[DIV_BITS];
			quo_q <= delta_mag[DIV_BITS-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DIV_BITS-2:0], rem_ge};
			rem_q <= rem_ge ? COUNT_BITS'(rem_sh - {1'b0, count_q}) : rem_sh[COUNT_BITS-1:0];
		end
		if (cmd.div_init) a_q <= delta_mag[DIV_BITS-1:0];
		if (cmd.mean_upd) begin
			b_q <= d2_mag[31:0];
			skip_q <= (delta_neg_q != delta2[DIV_BITS]) && (a_q != '0) && (d2_mag != '0);
			sat_q <= a_q[DIV_BITS-1] || (d2_mag[DIV_BITS:DIV_BITS-1] != 2'b00);
		end
		if (cmd.mul) prod_q <= a_q[31:0] * b_q;
		if (cmd.load_out)
			out_data <= {1'b0, changed_q, raised_q, count_q, m2_q, mean_q, max_q, min_q};
	end

endmodule
`default_nettype wire

// ----- src/sample_statistics_alarm_monitor.sv -----
// Channel   Direction  Payload
// s_axis    in         tuser: func[1:0]; tdata: sample[15:0], enable_flag[16]
// m_axis    out        tdata: min, max, mean, sum_sq_dev, count, status, changed
// cfg       in         cfg_we, cfg_index (register number), cfg_data
// Collect is the longest operation: the 33-step serial divider by the sample
// count dominates it. Other operations skip the divider.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
// While that register is still full, the controller holds the next result back.
// Reset is asynchronous and active low and loads the register defaults.
`default_nettype none
module sample_statistics_alarm_monitor (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [23:0]  s_axis_tdata,  // sample[15:0], enable_flag[16], zeros
	input  wire logic [1:0]   s_axis_tuser,  // func[1:0]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// min_value[15:0], max_value[31:16], mean_value[63:32], sum_sq_dev[126:64],
	// sample_count[158:127], status_bits[166:159], changed_bits[174:167], zero
	output logic [175:0]      m_axis_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);
	import ssam_pkg::*;

	ssam_cmd_t cmd;
	ssam_status_t status;
	logic idle;

	assign s_axis_tready = idle;

	ssam_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_axis_tvalid && idle),
		.status(status), .idle(idle), .cmd(cmd)
	);

	ssam_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_func(s_axis_tuser), .in_data(s_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_data(m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- src/ssam_checker.sv -----
`default_nettype none
module ssam_assertions (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [175:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	a_empty_stats: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[158:127] == 32'd0 |->
			m_axis_tdata[63:32] == 32'd0 && m_axis_tdata[126:64] == 63'd0)
		else $error("statistics not clear with zero count");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[158:127] != 32'd0 |->
			$signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[31:16]))
		else $error("min above max after collect");

endmodule

bind sample_statistics_alarm_monitor ssam_assertions u_ssam_assertions (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
